### hdl/lvw_pkg.sv
// ----------------------------------------------------------------------------
// lvw_pkg: shared constants of the 3D line voxel walker.
// Holds the default widths that the parts of the walker share.
// ----------------------------------------------------------------------------
package lvw_pkg;

    localparam int COORD_BITS_DEF = 5;
    localparam int FRAC_BITS_DEF  = 16;

endpackage

### hdl/lvw_setup.sv
// ----------------------------------------------------------------------------
// lvw_setup: front part of the walker.
// Accepts an endpoint pair, computes the squared distance, the length by a
// bit-serial square root and the three axis steps by a shared restoring
// divider, and hands a walk descriptor to the queue unless the length is below one.
// ----------------------------------------------------------------------------
module lvw_setup #(
    parameter int COORD_BITS = lvw_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = lvw_pkg::FRAC_BITS_DEF,
    parameter int LEN_BITS   = COORD_BITS + 2 + FRAC_BITS,
    parameter int POS_BITS   = COORD_BITS + FRAC_BITS + 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [COORD_BITS-1:0]      start_x,
    input  logic [COORD_BITS-1:0]      start_y,
    input  logic [COORD_BITS-1:0]      start_z,
    input  logic [COORD_BITS-1:0]      end_x,
    input  logic [COORD_BITS-1:0]      end_y,
    input  logic [COORD_BITS-1:0]      end_z,
    output logic                       d_valid,
    input  logic                       d_ready,
    output logic [3*POS_BITS-1:0]      d_pos,
    output logic [3*POS_BITS-1:0]      d_step,
    output logic [COORD_BITS+1:0]      d_count
);
    import lvw_pkg::*;

    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int D2_BITS   = 2 * COORD_BITS + 2;
    localparam int RAD_BITS  = D2_BITS + 2 * FRAC_BITS;
    localparam int SQ_ITERS  = RAD_BITS / 2 + RAD_BITS % 2;
    localparam int SQ_W      = 2 * SQ_ITERS;
    localparam int NUM_BITS  = COORD_BITS + 2 * FRAC_BITS;
    localparam int CNT_BITS  = $clog2(SQ_ITERS + NUM_BITS + 1);
    localparam int CNT_W     = COORD_BITS + 2;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SQ   = 5'b00010,
        S_DIV  = 5'b00100,
        S_OUT  = 5'b01000,
        S_D2   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic signed [DIFF_BITS-1:0] dif_reg [3];
    logic [COORD_BITS-1:0] st_reg [3];
    logic [SQ_W-1:0]       rad_reg;
    logic [SQ_ITERS+1:0]   rem_reg;
    logic [SQ_ITERS-1:0]   root_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [1:0]            ax_reg;
    logic [NUM_BITS-1:0]   num_reg;
    logic [LEN_BITS:0]     drem_reg;
    logic [POS_BITS-1:0]   step_reg [3];
    logic [D2_BITS-1:0]    d2_reg;

    function automatic logic [COORD_BITS-1:0] mag(input logic signed [DIFF_BITS-1:0] d);
        return d[DIFF_BITS-1] ? COORD_BITS'(-d) : COORD_BITS'(d);
    endfunction

    // Square of one axis difference magnitude, formed at the full width.
    function automatic logic [D2_BITS-1:0] sq(input logic signed [DIFF_BITS-1:0] d);
        logic [D2_BITS-1:0] m;
        m = D2_BITS'(mag(d));
        return m * m;
    endfunction

    // One digit of the square root.
    logic [SQ_ITERS+1:0] sq_trial;
    logic [SQ_ITERS+1:0] sq_cur;
    assign sq_cur   = {rem_reg[SQ_ITERS-1:0], rad_reg[SQ_W-1 -: 2]};
    assign sq_trial = {root_reg, 2'b01};

    // One bit of the division.
    logic [LEN_BITS:0] dv_cur;
    logic [LEN_BITS-1:0] len_w;
    assign len_w  = LEN_BITS'(root_reg);
    assign dv_cur = {drem_reg[LEN_BITS-1:0], num_reg[NUM_BITS-1]};

    logic [POS_BITS-1:0] q_mag;
    assign q_mag = POS_BITS'(num_reg);

    assign in_ready = (state_reg == S_IDLE);
    assign d_valid  = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid) state_next = S_D2;
            S_D2:   state_next = S_SQ;
            S_SQ:
            begin
                if (cnt_reg == CNT_BITS'(SQ_ITERS - 1))
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (root_reg[SQ_ITERS-1:FRAC_BITS] == '0)
                    state_next = S_IDLE;
                else if (cnt_reg == CNT_BITS'(NUM_BITS) && ax_reg == 2'd2)
                    state_next = S_OUT;
            end
            S_OUT:  if (d_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                st_reg[0] <= start_x;
                st_reg[1] <= start_y;
                st_reg[2] <= start_z;
                dif_reg[0] <= DIFF_BITS'(end_x) - DIFF_BITS'(start_x);
                dif_reg[1] <= DIFF_BITS'(end_y) - DIFF_BITS'(start_y);
                dif_reg[2] <= DIFF_BITS'(end_z) - DIFF_BITS'(start_z);
            end
            S_D2:
            begin
                d2_reg   <= sq(dif_reg[0]) + sq(dif_reg[1]) + sq(dif_reg[2]);
                rad_reg  <= SQ_W'({sq(dif_reg[0]) + sq(dif_reg[1]) + sq(dif_reg[2]),
                                   {(2*FRAC_BITS){1'b0}}});
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            S_SQ:
            begin
                rad_reg <= rad_reg << 2;
                if (sq_cur >= sq_trial)
                begin
                    rem_reg  <= sq_cur - sq_trial;
                    root_reg <= {root_reg[SQ_ITERS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= sq_cur;
                    root_reg <= {root_reg[SQ_ITERS-2:0], 1'b0};
                end
                // The last root digit also loads the first division.
                if (cnt_reg == CNT_BITS'(SQ_ITERS - 1))
                begin
                    cnt_reg  <= '0;
                    ax_reg   <= '0;
                    num_reg  <= NUM_BITS'({mag(dif_reg[0]), {(2*FRAC_BITS){1'b0}}});
                    drem_reg <= '0;
                end
                else
                    cnt_reg <= cnt_reg + 1'b1;
            end
            S_DIV:
            begin
                if (cnt_reg == CNT_BITS'(NUM_BITS))
                begin
                    // Quotient is complete in num_reg; store signed step.
                    step_reg[ax_reg] <= dif_reg[ax_reg][DIFF_BITS-1] ? -q_mag : q_mag;
                    ax_reg   <= ax_reg + 1'b1;
                    cnt_reg  <= '0;
                    drem_reg <= '0;
                    num_reg  <= NUM_BITS'({mag(dif_reg[(ax_reg == 2'd0) ? 1 : 2]),
                                           {(2*FRAC_BITS){1'b0}}});
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (dv_cur >= {1'b0, len_w})
                    begin
                        drem_reg <= dv_cur - {1'b0, len_w};
                        num_reg  <= {num_reg[NUM_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= dv_cur;
                        num_reg  <= {num_reg[NUM_BITS-2:0], 1'b0};
                    end
                end
            end
            default: ;
        endcase
    end

    // Walk descriptor toward the queue.
    logic [FRAC_BITS-1:0] half_w;
    assign half_w = {1'b1, {(FRAC_BITS-1){1'b0}}};
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            d_pos[a*POS_BITS +: POS_BITS]  = POS_BITS'({st_reg[a], half_w});
            d_step[a*POS_BITS +: POS_BITS] = step_reg[a];
        end
        d_count = CNT_W'(root_reg >> FRAC_BITS);
    end

    // A descriptor is only offered with a nonzero cell count.
    property p_len_nonzero;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> (d_count != '0);
    endproperty
    a_len_nonzero: assert property (p_len_nonzero) else $error("zero walk sent");

    property p_accept_idle;
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_D2);
    endproperty
    a_accept_idle: assert property (p_accept_idle) else $error("accept lost");

    property p_d2_zero;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> (d2_reg != '0);
    endproperty
    a_d2_zero: assert property (p_d2_zero) else $error("zero distance walked");

endmodule

### hdl/lvw_queue.sv
// ----------------------------------------------------------------------------
// lvw_queue: two-entry queue of walk descriptors between setup and walk.
// Lets the setup part start the next item while a walk is still running.
// ----------------------------------------------------------------------------
module lvw_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             w_valid,
    output logic             w_ready,
    input  logic [WIDTH-1:0] w_data,
    output logic             r_valid,
    input  logic             r_ready,
    output logic [WIDTH-1:0] r_data
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;

    assign w_ready = (cnt_reg != 2'd2);
    assign r_valid = (cnt_reg != 2'd0);
    assign r_data  = mem_reg[rp_reg];

    // Storage.
    always_ff @(posedge clk)
    begin
        if (w_valid && w_ready)
            mem_reg[wp_reg] <= w_data;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (w_valid && w_ready) wp_reg <= ~wp_reg;
            if (r_valid && r_ready) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'((w_valid && w_ready) ? 1 : 0)
                               - 2'((r_valid && r_ready) ? 1 : 0);
        end
    end

    property p_no_over;
        @(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3;
    endproperty
    a_no_over: assert property (p_no_over) else $error("queue overflow");

    property p_ptr;
        @(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> (wp_reg == rp_reg);
    endproperty
    a_ptr: assert property (p_ptr) else $error("queue pointers out of step");

    property p_full_hold;
        @(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !r_ready) |=> (cnt_reg == 2'd2);
    endproperty
    a_full_hold: assert property (p_full_hold) else $error("queue lost an entry");

endmodule

### hdl/lvw_walk.sv
// ----------------------------------------------------------------------------
// lvw_walk: back part of the walker.
// Steps the position of one descriptor and sends one cell per accepted
// item on the output channel, through a registered output stage.
// ----------------------------------------------------------------------------
module lvw_walk #(
    parameter int COORD_BITS = lvw_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = lvw_pkg::FRAC_BITS_DEF,
    parameter int POS_BITS   = COORD_BITS + FRAC_BITS + 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  d_valid,
    output logic                  d_ready,
    input  logic [3*POS_BITS-1:0] d_pos,
    input  logic [3*POS_BITS-1:0] d_step,
    input  logic [COORD_BITS+1:0] d_count,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_BITS-1:0] cell_x,
    output logic [COORD_BITS-1:0] cell_y,
    output logic [COORD_BITS-1:0] cell_z,
    output logic                  last_cell
);
    import lvw_pkg::*;

    logic                  busy_reg;
    logic [POS_BITS-1:0]   pos_reg  [3];
    logic [POS_BITS-1:0]   step_reg [3];
    logic [COORD_BITS+1:0] left_reg;
    logic                  ov_reg;
    logic [COORD_BITS-1:0] ox_reg, oy_reg, oz_reg;
    logic                  ol_reg;
    logic [POS_BITS-1:0]   np [3];
    logic                  emit;

    assign d_ready = !busy_reg;
    assign emit    = busy_reg && (!ov_reg || out_ready);

    always_comb
    begin
        for (int a = 0; a < 3; a++)
            np[a] = pos_reg[a] + step_reg[a];
    end

    // Walk control and output stage flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (d_valid && d_ready)
                busy_reg <= 1'b1;
            else if (emit && left_reg == (COORD_BITS+2)'(1))
                busy_reg <= 1'b0;
            if (emit)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    // Position and output payload.
    always_ff @(posedge clk)
    begin
        if (d_valid && d_ready)
        begin
            for (int a = 0; a < 3; a++)
            begin
                pos_reg[a]  <= d_pos[a*POS_BITS +: POS_BITS];
                step_reg[a] <= d_step[a*POS_BITS +: POS_BITS];
            end
            left_reg <= d_count;
        end
        else if (emit)
        begin
            for (int a = 0; a < 3; a++)
                pos_reg[a] <= np[a];
            left_reg <= left_reg - 1'b1;
            ox_reg <= np[0][FRAC_BITS +: COORD_BITS];
            oy_reg <= np[1][FRAC_BITS +: COORD_BITS];
            oz_reg <= np[2][FRAC_BITS +: COORD_BITS];
            ol_reg <= (left_reg == (COORD_BITS+2)'(1));
        end
    end

    assign out_valid = ov_reg;
    assign cell_x    = ox_reg;
    assign cell_y    = oy_reg;
    assign cell_z    = oz_reg;
    assign last_cell = ol_reg;

    property p_left;
        @(posedge clk) disable iff (!rst_n)
        busy_reg |-> (left_reg != '0);
    endproperty
    a_left: assert property (p_left) else $error("walk with no cells left");

    property p_last_ends;
        @(posedge clk) disable iff (!rst_n)
        (emit && left_reg == (COORD_BITS+2)'(1)) |=> (!busy_reg && ol_reg);
    endproperty
    a_last_ends: assert property (p_last_ends) else $error("last cell not marked");

    property p_hold;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(ox_reg) && out_valid;
    endproperty
    a_hold: assert property (p_hold) else $error("stalled cell changed");

endmodule

### hdl/line_voxel_walker_3d.sv
// ----------------------------------------------------------------------------
// line_voxel_walker_3d: sampled 3D line walk between two grid cells.
// Top level joining the setup part, the descriptor queue and the walk part.
// ----------------------------------------------------------------------------
// Usage:
// An item on the input channel (in_valid/in_ready) is a start and an end
// cell. For it the block sends floor(length) items on the output channel
// (out_valid/out_ready), one cell each, the last one marked by last_cell.
// A line shorter than one cell sends nothing.
// Setup forms the squared distance, then the square root one digit at a
// time, then the three divisions one after another, one quotient bit at a
// time. A new item is taken only after the descriptor of the last one is
// handed to the queue, and a line shorter than one cell frees the input
// once its square root is done. The bit-serial divider sets the rate.
// The walk sends one cell per cycle while out_ready is high; the first
// cell is registered in the output stage after the descriptor is loaded.
// A two-entry queue lets setup of the next item overlap a running walk.
// A stalled receiver holds the current cell in the output register and
// the walk waits; setup goes on until the queue is full.
// Reset clears all control state; no item is in flight afterwards.
// ----------------------------------------------------------------------------
module line_voxel_walker_3d #(
    parameter int COORD_BITS = lvw_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = lvw_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] start_z,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    input  logic [COORD_BITS-1:0] end_z,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_BITS-1:0] cell_x,
    output logic [COORD_BITS-1:0] cell_y,
    output logic [COORD_BITS-1:0] cell_z,
    output logic                  last_cell
);
    import lvw_pkg::*;

    localparam int POS_BITS = COORD_BITS + FRAC_BITS + 2;
    localparam int QW       = 6 * POS_BITS + COORD_BITS + 2;

    logic                  sv, sr, qv, qr;
    logic [3*POS_BITS-1:0] s_pos, s_step, q_pos, q_step;
    logic [COORD_BITS+1:0] s_cnt, q_cnt;

    lvw_setup #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS),
                .POS_BITS(POS_BITS)) u_setup (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .start_x(start_x), .start_y(start_y), .start_z(start_z),
        .end_x(end_x), .end_y(end_y), .end_z(end_z),
        .d_valid(sv), .d_ready(sr), .d_pos(s_pos), .d_step(s_step),
        .d_count(s_cnt)
    );

    lvw_queue #(.WIDTH(QW)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .w_valid(sv), .w_ready(sr), .w_data({s_pos, s_step, s_cnt}),
        .r_valid(qv), .r_ready(qr), .r_data({q_pos, q_step, q_cnt})
    );

    lvw_walk #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS),
               .POS_BITS(POS_BITS)) u_walk (
        .clk(clk), .rst_n(rst_n),
        .d_valid(qv), .d_ready(qr), .d_pos(q_pos), .d_step(q_step),
        .d_count(q_cnt),
        .out_valid(out_valid), .out_ready(out_ready),
        .cell_x(cell_x), .cell_y(cell_y), .cell_z(cell_z),
        .last_cell(last_cell)
    );

endmodule
